FILE: hw/rtl/dpsm_pkg.sv
package dpsm_pkg;

  // voice count and derived sizes
  localparam int VOICES    = 4;
  localparam int VOICE_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MIX_SHIFT = $clog2(VOICES);
  localparam int SUM_W     = 8 + MIX_SHIFT;

  localparam int PHASE_W   = 16;
  localparam int RATE_W    = 8;
  localparam int ADDR_W    = 8;
  localparam int WAVE_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [PHASE_W-1:0] PITCH_RESET = 16'd220;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 8'd7;
  localparam logic [WAVE_W-1:0]  MID_LEVEL   = 8'd128;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_BASE_PITCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_STEP = 1'b1;

  // request kinds on s_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // sequencer controls for the phase unit
  typedef struct packed {
    logic               start;  // clear the per-voice offset
    logic               step;   // update the selected voice
    logic [VOICE_W-1:0] voice;
  } phase_ctl_t;

endpackage

FILE: hw/rtl/dds_phase_shift_saw_mixer.sv
// channel | dir | tdata (low bit up)                  | tuser
// s_      | in  | table_index[7:0], table_value[15:8] | op (0 tick, 1 table load)
// m_      | out | sample[7:0]                         | -
// cfg_    | in  | index 0 base_pitch, 1 drift_step    | -
//
// a table load stays in IDLE, so s_tready stays high; a tick walks the voices one per cycle
// through the shared phase adder and the single table read port, then passes LAST and EMIT
// before the next request is accepted
// rst is synchronous: phases zero, registers at 220 / 7; the wave table is not cleared
// s_tready is low while a tick is in flight; a finished sample waits in the output
// register, and a following tick holds only at its final step until it is taken
module dds_phase_shift_saw_mixer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // table_index, table_value
  input  logic                           s_tuser,   // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // sample
  input  logic                           cfg_we,
  input  logic [dpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpsm_pkg::CFG_W-1:0]     cfg_data
);
  import dpsm_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    LAST,
    EMIT
  } state_t;

  state_t               state;
  logic [VOICE_W-1:0]   voice;
  logic                 rd_valid;   // table read data arrives this cycle
  logic signed [SUM_W-1:0] sum;
  logic [PHASE_W-1:0]   base_pitch;
  logic [RATE_W-1:0]    drift_step;

  phase_ctl_t           ctl;
  logic                 s_accept;
  logic                 load_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic signed [WAVE_W-1:0] rd_data;
  logic [SUM_W-1:0]     biased;

  localparam logic [SUM_W-1:0] MID_BIAS = SUM_W'(MID_LEVEL) << MIX_SHIFT;

  assign s_tready = (state == IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign load_en  = s_accept && (s_tuser == OP_LOAD);

  assign ctl.start = s_accept && (s_tuser == OP_TICK);
  assign ctl.step  = (state == RUN);
  assign ctl.voice = voice;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_pitch <= PITCH_RESET;
      drift_step <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PITCH: base_pitch <= cfg_data;
        REG_DRIFT_STEP: drift_step <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  dpsm_phase_unit u_phase (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .base_pitch (base_pitch),
    .drift_step (drift_step),
    .table_addr (rd_addr)
  );

  dpsm_wave_ram u_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (s_tdata[7:0]),
    .wr_data (s_tdata[15:8]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // bias keeps the sum non-negative, so the top byte is the floor of the mean, offset by 128
  assign biased = SUM_W'(sum) + MID_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      voice    <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in EMIT the output register is refilled by the state machine below
      if (m_tvalid && m_tready && (state != EMIT)) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == RUN);
      if (rd_valid) begin
        sum <= sum + SUM_W'(rd_data);
      end

      case (state)
        IDLE: begin
          if (ctl.start) begin
            voice <= '0;
            sum   <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          voice <= voice + 1'b1;
          if (voice == VOICE_W'(VOICES - 1)) begin
            state <= LAST;
          end
        end
        LAST: begin
          state <= EMIT;
        end
        EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= biased[MIX_SHIFT +: 8];
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/dpsm_wave_ram.sv
module dpsm_wave_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [dpsm_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [dpsm_pkg::WAVE_W-1:0]  wr_data,
  input  logic [dpsm_pkg::ADDR_W-1:0]  rd_addr,
  output logic [dpsm_pkg::WAVE_W-1:0]  rd_data
);
  import dpsm_pkg::*;

  logic [WAVE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/dpsm_phase_unit.sv
module dpsm_phase_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  dpsm_pkg::phase_ctl_t          ctl,
  input  logic [dpsm_pkg::PHASE_W-1:0]  base_pitch,
  input  logic [dpsm_pkg::RATE_W-1:0]   drift_step,
  output logic [dpsm_pkg::ADDR_W-1:0]   table_addr
);
  import dpsm_pkg::*;

  logic [PHASE_W-1:0] phase [VOICES];
  logic [PHASE_W-1:0] ofs;          // drift_step times voice number
  logic [PHASE_W-1:0] acc_add;
  logic [PHASE_W-1:0] acc_next;

  // shared adder: pitch step, then drift offset when the new table index is zero
  always_comb begin
    acc_add    = phase[ctl.voice] + base_pitch;
    table_addr = acc_add[PHASE_W-1 -: ADDR_W];
    acc_next   = (table_addr == '0) ? acc_add + ofs : acc_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        phase[i] <= '0;
      end
      ofs <= '0;
    end else if (ctl.start) begin
      ofs <= '0;
    end else if (ctl.step) begin
      phase[ctl.voice] <= acc_next;
      ofs              <= ofs + PHASE_W'(drift_step);
    end
  end

endmodule
